[src/bbcr_pkg.sv]
// ----------------------------------------------------------------------------
// bbcr_pkg: buffer cache replacement package
// Field widths, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package bbcr_pkg;

  // parameter defaults
  localparam int SLOTS_DEF     = 32;
  localparam int DISK_SIZE_DEF = 8192;
  localparam int AGE_BITS_DEF  = 16;

  // port field widths
  localparam int ACT_W     = 2;
  localparam int BLK_W     = 14;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;
  localparam int WB_BLK_W  = 13;

  // request codes
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DIRTY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

endpackage

[src/block_buffer_cache_replacement_unit.sv]
// ----------------------------------------------------------------------------
// block_buffer_cache_replacement_unit: buffer slot replacement table
// Fully associative table of buffer slots tagged with disk block numbers.
// Allocate (age all, take lowest free slot or evict the oldest), lookup and
// mark-dirty, each answered by exactly one result transaction.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  request  | in        | start, busy        | action, block_num
//  result   | out       | done (strobe)      | status, slot_index,
//           |           |                    | writeback_needed, writeback_block
//
//  Timing: an in-bound request makes one sequential pass over the age/tag RAM,
//  one slot per cycle through its single read port with registered read data,
//  then commits the pick in a final state before the done strobe shows. busy
//  drops as done shows, so a new in-bound request is taken only after the last
//  one is answered. An out-of-bound request answers the next cycle and never
//  raises busy.
//  Reset: rst clears all in-use and dirty bits; no clearing pass is needed,
//  since the age/tag of a slot is written at allocation before any use.
//  busy is high while a request is in flight; a new request can be taken in
//  the same cycle the result strobe is shown. The receiver cannot stall.
//
module block_buffer_cache_replacement_unit #(
  parameter int SLOTS     = bbcr_pkg::SLOTS_DEF,
  parameter int DISK_SIZE = bbcr_pkg::DISK_SIZE_DEF,
  parameter int AGE_BITS  = bbcr_pkg::AGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [bbcr_pkg::ACT_W-1:0]    action,
  input  logic [bbcr_pkg::BLK_W-1:0]    block_num,
  // result
  output logic                          done,
  output logic [bbcr_pkg::STATUS_W-1:0] status,
  output logic [bbcr_pkg::SLOT_W-1:0]   slot_index,
  output logic                          writeback_needed,
  output logic [bbcr_pkg::WB_BLK_W-1:0] writeback_block
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TAG_W = $clog2(DISK_SIZE);
  localparam int RAM_W = AGE_BITS + TAG_W;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state, state_next;

  // request context
  logic [bbcr_pkg::ACT_W-1:0] act_r;
  logic [TAG_W-1:0]           blk_r;

  // scan pipeline: cnt issues reads, ri is the slot whose data is back
  logic [CNT_W-1:0] cnt;
  logic             rv;
  logic [IDX_W-1:0] ri;

  // per-slot flags
  logic [SLOTS-1:0] in_use;
  logic [SLOTS-1:0] dirty;

  // scan results
  logic                found;      // free slot (allocate) or hit (lookup, mark-dirty)
  logic [IDX_W-1:0]    pick;
  logic [AGE_BITS-1:0] best_age;
  logic [IDX_W-1:0]    best_idx;
  logic [TAG_W-1:0]    best_tag;

  // RAM: {age, tag} per slot
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;

  logic [AGE_BITS-1:0] rd_age;
  logic [TAG_W-1:0]    rd_tag;
  logic [AGE_BITS-1:0] age_inc;

  logic                         accept;
  logic                         oob;
  logic                         is_alloc;
  logic                         scan_end;
  logic [IDX_W-1:0]             alloc_idx;
  logic [IDX_W-1:0]             res_idx;
  logic [IDX_W+bbcr_pkg::SLOT_W-1:0]   idx_ext;
  logic [TAG_W+bbcr_pkg::WB_BLK_W-1:0] tag_ext;

  bbcr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign oob      = ({1'b0, block_num} >= (bbcr_pkg::BLK_W + 1)'(DISK_SIZE));
  assign is_alloc = (act_r == bbcr_pkg::ACT_ALLOC);

  assign rd_age  = ram_rdata[RAM_W-1:TAG_W];
  assign rd_tag  = ram_rdata[TAG_W-1:0];
  // ages saturate
  assign age_inc = (rd_age == AGE_MAX) ? rd_age : rd_age + AGE_BITS'(1);

  assign scan_end  = rv && (ri == IDX_W'(SLOTS - 1));
  // lowest free slot wins; else the oldest one
  assign alloc_idx = found ? pick : best_idx;
  assign res_idx   = is_alloc ? alloc_idx : pick;
  assign idx_ext   = {{bbcr_pkg::SLOT_W{1'b0}}, res_idx};
  assign tag_ext   = {{bbcr_pkg::WB_BLK_W{1'b0}}, best_tag};

  // RAM write: age bump during the allocate scan, new entry at commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ri;
    ram_wdata = {age_inc, rd_tag};
    if (state == S_SCAN && rv && is_alloc) begin
      ram_we = 1'b1;
    end else if (state == S_FIN && is_alloc) begin
      ram_we    = 1'b1;
      ram_waddr = alloc_idx;
      ram_wdata = {{AGE_BITS{1'b0}}, blk_r};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !oob) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      rv     <= 1'b0;
      cnt    <= '0;
      found  <= 1'b0;
      in_use <= '0;
      dirty  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          cnt   <= '0;
          rv    <= 1'b0;
          found <= 1'b0;
          // out-of-bound requests answer straight from idle
          done  <= accept && oob;
        end
        S_SCAN: begin
          done <= 1'b0;
          if (cnt != CNT_W'(SLOTS)) begin
            cnt <= cnt + CNT_W'(1);
          end
          rv <= (cnt != CNT_W'(SLOTS));
          if (rv && !found) begin
            if (is_alloc) begin
              found <= !in_use[ri];
            end else begin
              found <= in_use[ri] && (rd_tag == blk_r);
            end
          end
        end
        S_FIN: begin
          done <= 1'b1;
          if (is_alloc) begin
            in_use[alloc_idx] <= 1'b1;
            dirty[alloc_idx]  <= 1'b0;
          end else if (found && act_r == bbcr_pkg::ACT_DIRTY) begin
            dirty[pick] <= 1'b1;
          end
        end
        default: begin
          done <= 1'b0;
          rv   <= 1'b0;
        end
      endcase
    end
  end

  // payload and scan data
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action;
      blk_r <= block_num[TAG_W-1:0];
    end
    if (state == S_SCAN) begin
      ri <= cnt[IDX_W-1:0];
    end
    if (state == S_SCAN && rv) begin
      if (!found) begin
        pick <= ri;
      end
      // strict compare keeps the lowest index on a tie
      if (ri == '0 || age_inc > best_age) begin
        best_age <= age_inc;
        best_idx <= ri;
        best_tag <= rd_tag;
      end
    end
    if (state == S_IDLE && accept && oob) begin
      status           <= bbcr_pkg::ST_OOB;
      slot_index       <= '0;
      writeback_needed <= 1'b0;
      writeback_block  <= '0;
    end else if (state == S_FIN) begin
      if (is_alloc || found) begin
        status     <= bbcr_pkg::ST_OK;
        slot_index <= idx_ext[bbcr_pkg::SLOT_W-1:0];
      end else begin
        status     <= bbcr_pkg::ST_MISS;
        slot_index <= '0;
      end
      if (is_alloc && !found && dirty[best_idx]) begin
        writeback_needed <= 1'b1;
        writeback_block  <= tag_ext[bbcr_pkg::WB_BLK_W-1:0];
      end else begin
        writeback_needed <= 1'b0;
        writeback_block  <= '0;
      end
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a transaction is in flight");

  a_inbound_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !oob) |=> busy)
    else $error("in-bound request did not start a scan");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bbcr_pkg::ST_OK) |-> (slot_index == '0 && !writeback_needed))
    else $error("failed request carries slot or write-back");

  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    (done && writeback_needed) |-> (status == bbcr_pkg::ST_OK && $past(is_alloc)))
    else $error("write-back outside a successful allocate");

endmodule

[src/bbcr_ram.sv]
// ----------------------------------------------------------------------------
// bbcr_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
